/* sv/clp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clp_pkg
// Shared constants, types and character class helpers of the command line
// prefix/code parser.
// ----------------------------------------------------------------------------
package clp_pkg;

    // default line buffer depth in characters
    localparam int unsigned LINE_BUFFER_SIZE_DEF = 32;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_MASK = 8'hDF;

    // minimum line length that gives a prefix or a code
    localparam int unsigned MIN_LINE_LEN = 2;

    // code clamp value
    localparam logic [15:0] CODE_MAX = 16'hFFFF;

    // character word moved from the input register to the parser core
    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
    } t_char_word;

    // space, tab, line feed, vertical tab, form feed, carriage return
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // line terminators
    function automatic logic is_end(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR) || (c == CH_NUL);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
    endfunction

endpackage : clp_pkg
`default_nettype wire

/* sv/clp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clp_cmd_if / clp_res_if
// Valid/ready channels for incoming characters and for parse results.
// ----------------------------------------------------------------------------
interface clp_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface : clp_cmd_if

interface clp_res_if;
    logic        valid;
    logic        ready;
    logic        prefix_valid;
    logic [7:0]  prefix_letter;
    logic        code_valid;
    logic [15:0] code_value;
    logic        code_saturated;

    modport source (
        output valid, output prefix_valid, output prefix_letter,
        output code_valid, output code_value, output code_saturated,
        input  ready
    );
    modport sink (
        input  valid, input prefix_valid, input prefix_letter,
        input  code_valid, input code_value, input code_saturated,
        output ready
    );
endinterface : clp_res_if
`default_nettype wire

/* sv/clp_char_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clp_char_reg
// Input register: captures one character word and hands it to the parser
// core when the core can take it.
// ----------------------------------------------------------------------------
module clp_char_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    clp_cmd_if.sink                 i_cmd,
    input  wire logic               i_core_ready,
    output clp_pkg::t_char_word     o_word
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_ch;
    logic       w_load;

    // take a new word when empty or when the held one moves on
    assign i_cmd.ready = !r_valid || i_core_ready;
    assign w_load      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_core_ready) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // character payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ch <= i_cmd.ch;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.ch    = r_ch;

endmodule : clp_char_reg
`default_nettype wire

/* sv/clp_parse_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clp_parse_core
// Line state machine, prefix/code tracking and the result register.
// ----------------------------------------------------------------------------
module clp_parse_core #(
    parameter int unsigned LINE_BUFFER_SIZE = clp_pkg::LINE_BUFFER_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire clp_pkg::t_char_word i_word,
    output logic                    o_core_ready,
    clp_res_if.source               o_res
);

    localparam int unsigned CNT_W = $clog2(LINE_BUFFER_SIZE + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_BUFFER_SIZE);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(clp_pkg::MIN_LINE_LEN);

    // parse modes
    localparam logic [1:0] MODE_WAIT = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_SKIP = 2'd2;

    logic [1:0]       r_mode,         n_mode;
    logic [CNT_W-1:0] r_count,        n_count;
    logic [7:0]       r_first,        n_first;
    logic             r_second_digit, n_second_digit;
    logic             r_running,      n_running;
    logic [15:0]      r_acc,          n_acc;
    logic             r_clamped,      n_clamped;

    logic             r_out_valid,    n_out_valid;
    logic             r_prefix_valid;
    logic [7:0]       r_prefix_letter;
    logic             r_code_valid;
    logic [15:0]      r_code_value;
    logic             r_code_saturated;

    logic             w_step;
    logic             w_emit;
    logic             w_digit;
    logic             w_long;
    logic [19:0]      w_acc_next;

    assign o_core_ready = !r_out_valid || o_res.ready;
    assign w_step       = i_word.valid && o_core_ready;
    assign w_digit      = clp_pkg::is_digit(i_word.ch);
    assign w_long       = (r_first != clp_pkg::CH_NUL) && (r_count >= CNT_MIN);

    // times ten plus digit, as shifts and adds
    assign w_acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {16'd0, i_word.ch[3:0]};

    // next line state
    always_comb begin
        n_mode         = r_mode;
        n_count        = r_count;
        n_first        = r_first;
        n_second_digit = r_second_digit;
        n_running      = r_running;
        n_acc          = r_acc;
        n_clamped      = r_clamped;
        w_emit         = 1'b0;
        if (w_step) begin
            unique case (r_mode)
                MODE_WAIT: begin
                    if (!clp_pkg::is_ws(i_word.ch)) begin
                        n_first        = i_word.ch;
                        n_count        = CNT_ONE;
                        n_second_digit = 1'b0;
                        n_running      = 1'b0;
                        n_acc          = '0;
                        n_clamped      = 1'b0;
                        n_mode         = MODE_READ;
                    end
                end
                MODE_READ: begin
                    if (r_count >= CNT_FULL) begin
                        n_mode = MODE_SKIP;
                    end else if (!clp_pkg::is_end(i_word.ch)) begin
                        if (r_count == CNT_ONE) begin
                            n_second_digit = w_digit;
                            n_running      = w_digit;
                        end else if (r_running && !w_digit) begin
                            n_running = 1'b0;
                        end
                        // digit run from position one keeps accumulating
                        if (w_digit && (r_count == CNT_ONE || r_running) && !r_clamped) begin
                            if (w_acc_next > {4'd0, clp_pkg::CODE_MAX}) begin
                                n_acc     = clp_pkg::CODE_MAX;
                                n_clamped = 1'b1;
                            end else begin
                                n_acc = w_acc_next[15:0];
                            end
                        end
                        n_count = r_count + CNT_ONE;
                    end else begin
                        n_mode = MODE_WAIT;
                        w_emit = 1'b1;
                    end
                end
                default: begin
                    if (clp_pkg::is_end(i_word.ch)) begin
                        n_mode = MODE_WAIT;
                    end
                end
            endcase
        end
    end

    // result valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_WAIT;
            r_count        <= '0;
            r_first        <= '0;
            r_second_digit <= 1'b0;
            r_running      <= 1'b0;
            r_acc          <= '0;
            r_clamped      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_mode         <= n_mode;
            r_count        <= n_count;
            r_first        <= n_first;
            r_second_digit <= n_second_digit;
            r_running      <= n_running;
            r_acc          <= n_acc;
            r_clamped      <= n_clamped;
            r_out_valid    <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_prefix_valid   <= w_long && clp_pkg::is_letter(r_first);
            r_prefix_letter  <= (w_long && clp_pkg::is_letter(r_first))
                              ? (r_first & clp_pkg::CASE_MASK) : 8'd0;
            r_code_valid     <= w_long && r_second_digit;
            r_code_value     <= (w_long && r_second_digit) ? r_acc : 16'd0;
            r_code_saturated <= w_long && r_second_digit && r_clamped;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.prefix_valid   = r_prefix_valid;
    assign o_res.prefix_letter  = r_prefix_letter;
    assign o_res.code_valid     = r_code_valid;
    assign o_res.code_value     = r_code_value;
    assign o_res.code_saturated = r_code_saturated;

endmodule : clp_parse_core
`default_nettype wire

/* sv/command_line_prefix_code_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_prefix_code_parser
// Character stream to command line prefix/code results.
// ----------------------------------------------------------------------------
// Takes one character word per clock while the result side is ready and
// gives one result word per completed line (line feed, carriage return or
// NUL ends a line). Leading whitespace is skipped. The result carries the
// upper-case letter prefix when the first character is a letter and the
// decimal code read from position one, clamped at 65535 with a flag; both
// need a line of at least two characters. Lines of LINE_BUFFER_SIZE
// characters or more are dropped up to the next end character with no
// result. A character passes the input register and then the line state
// and result register; each takes a word every cycle, so throughput is
// one character per clock while the result side is ready.
module command_line_prefix_code_parser #(
    parameter int unsigned LINE_BUFFER_SIZE = clp_pkg::LINE_BUFFER_SIZE_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    clp_cmd_if.sink     i_cmd,
    clp_res_if.source   o_res
);

    clp_pkg::t_char_word w_word;
    logic                w_core_ready;

    // input register
    clp_char_reg u_char_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_core_ready (w_core_ready),
        .o_word       (w_word)
    );

    // line state and result register
    clp_parse_core #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_parse_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (w_word),
        .o_core_ready (w_core_ready),
        .o_res        (o_res)
    );

endmodule : command_line_prefix_code_parser
`default_nettype wire
